// ===== rtl/cfba_pkg.sv =====
package cfba_pkg;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned START_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ALLOC_W = 10;
  localparam int unsigned BSIZE_W = 16;

  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 16'd512;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ALREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SIZE_W-1:0]  size_bytes;
    logic [START_W-1:0] start_block;
    logic [COUNT_W-1:0] block_count;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ALLOC_W-1:0] alloc_start;
  } rsp_t;

endpackage

// ===== rtl/cfba_if.sv =====
interface cfba_req_if;
  logic                            valid;
  logic                            ready;
  logic [cfba_pkg::CMD_W-1:0]      command;
  logic [cfba_pkg::SIZE_W-1:0]     size_bytes;
  logic [cfba_pkg::START_W-1:0]    start_block;
  logic [cfba_pkg::COUNT_W-1:0]    block_count;

  modport source (output valid, command, size_bytes, start_block, block_count,
                  input ready);
  modport sink   (input valid, command, size_bytes, start_block, block_count,
                  output ready);
endinterface

interface cfba_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [cfba_pkg::STAT_W-1:0]     status;
  logic [cfba_pkg::ALLOC_W-1:0]    alloc_start;

  modport source (output valid, status, alloc_start, input ready);
  modport sink   (input valid, status, alloc_start, output ready);
endinterface

interface cfba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfba_pkg::BSIZE_W-1:0]    block_size;

  modport source (output valid, block_size, input ready);
  modport sink   (input valid, block_size, output ready);
endinterface

// ===== rtl/contiguous_first_fit_block_allocator_unit.sv =====
// First-fit allocator over a bitmap of TOTAL_BLOCKS disk blocks held in one
// single-port-read, single-port-write memory. After reset the block clears
// every bitmap entry and accepts no request meanwhile; block_size writes
// are taken at any time and apply to requests accepted after them. An
// allocate beat first divides the byte size by the block size (one quotient
// bit per cycle, then a hand-over of the quotient), then scans at one bitmap
// entry per cycle, then marks the found blocks one after another; a zero
// block_size answers at once. A free beat walks its blocks at one bitmap
// entry per cycle. One request is worked on at a time, and a finished result
// sits in an output register so the next request can be accepted while it
// waits.
module contiguous_first_fit_block_allocator_unit #(
  parameter int unsigned TOTAL_BLOCKS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfba_req_if.sink   req_i,
  cfba_rsp_if.source rsp_o,
  cfba_cfg_if.sink   cfg_i
);

  logic [cfba_pkg::BSIZE_W-1:0] block_size_q;
  logic                         out_vld_q;
  cfba_pkg::rsp_t               out_q;
  cfba_pkg::cmd_t               cmd;
  cfba_pkg::rsp_t               eng_rsp;
  logic                         eng_idle, eng_vld, eng_rdy;
  logic                         req_fire;

  assign cmd = '{command:     req_i.command,
                 size_bytes:  req_i.size_bytes,
                 start_block: req_i.start_block,
                 block_count: req_i.block_count};

  assign req_i.ready = eng_idle;
  assign req_fire    = req_i.valid && eng_idle;
  assign cfg_i.ready = 1'b1;

  // The output slot takes a new result when empty or being drained.
  assign eng_rdy = !out_vld_q || rsp_o.ready;

  cfba_engine #(
    .TOTAL_BLOCKS (TOTAL_BLOCKS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (req_fire),
    .cmd_i        (cmd),
    .block_size_i (block_size_q),
    .idle_o       (eng_idle),
    .rsp_valid_o  (eng_vld),
    .rsp_ready_i  (eng_rdy),
    .rsp_o        (eng_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= cfba_pkg::BLOCK_SIZE_RST;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        block_size_q <= cfg_i.block_size;
      end
      if (eng_rdy) begin
        out_vld_q <= eng_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_rdy && eng_vld) begin
      out_q <= eng_rsp;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.alloc_start = out_q.alloc_start;

endmodule

// ===== rtl/cfba_div.sv =====
module cfba_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cfba_pkg::SIZE_W-1:0]    dividend_i,
  input  logic [cfba_pkg::BSIZE_W-1:0]   divisor_i,
  output logic                           done_o,
  output logic [cfba_pkg::SIZE_W-1:0]    quot_o
);

  localparam int unsigned CNT_W = $clog2(cfba_pkg::SIZE_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [cfba_pkg::SIZE_W-1:0]   quo_q, quo_d;
  logic [cfba_pkg::BSIZE_W-1:0]  rem_q, rem_d;
  logic [cfba_pkg::BSIZE_W-1:0]  dvs_q, dvs_d;
  logic [cfba_pkg::BSIZE_W:0]    rem_sh;
  logic [cfba_pkg::BSIZE_W:0]    diff;
  logic                          fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_q, quo_q[cfba_pkg::SIZE_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[cfba_pkg::SIZE_W-2:0], fits};
      rem_d = fits ? diff[cfba_pkg::BSIZE_W-1:0] : rem_sh[cfba_pkg::BSIZE_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(cfba_pkg::SIZE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/cfba_engine.sv =====
module cfba_engine #(
  parameter int unsigned TOTAL_BLOCKS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  cfba_pkg::cmd_t                cmd_i,
  input  logic [cfba_pkg::BSIZE_W-1:0]  block_size_i,
  output logic                          idle_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output cfba_pkg::rsp_t                rsp_o
);

  localparam int unsigned AW  = $clog2(TOTAL_BLOCKS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned IW  = ((AW + 1 > cfba_pkg::START_W) ? AW + 1 : cfba_pkg::START_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(TOTAL_BLOCKS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MARK  = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic [CW-1:0]                 ra_q, ra_d;
  logic                          pv_q, pv_d;
  logic                          poob_q, poob_d;
  logic [AW-1:0]                 paddr_q, paddr_d;
  logic [CW-1:0]                 run_q, run_d;
  logic [CW-1:0]                 need_q, need_d;
  logic [AW-1:0]                 first_q, first_d;
  logic [AW-1:0]                 last_q, last_d;
  logic [AW-1:0]                 mk_q, mk_d;
  logic [IW-1:0]                 fi_q, fi_d;
  logic [cfba_pkg::COUNT_W-1:0]  frem_q, frem_d;
  cfba_pkg::rsp_t                res_q, res_d;

  logic                          mem [TOTAL_BLOCKS];
  logic                          rdata_q;
  logic                          re, we, wdata;
  logic [AW-1:0]                 raddr, waddr;

  logic                          div_start, div_done;
  logic [cfba_pkg::SIZE_W-1:0]   div_quot;
  logic [CW-1:0]                 run_inc;
  logic [CW-1:0]                 first_w;
  logic                          fi_oob;
  logic [AW+cfba_pkg::ALLOC_W-1:0] first_ext;

  cfba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_i.size_bytes),
    .divisor_i  (block_size_i),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign run_inc   = run_q + 1'b1;
  assign first_w   = CW'(paddr_q) + 1'b1 - need_q;
  assign fi_oob    = fi_q >= IW'(TOTAL_BLOCKS);
  assign first_ext = {{cfba_pkg::ALLOC_W{1'b0}}, first_q};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ra_d      = ra_q;
    pv_d      = 1'b0;
    poob_d    = 1'b0;
    paddr_d   = paddr_q;
    run_d     = run_q;
    need_d    = need_q;
    first_d   = first_q;
    last_d    = last_q;
    mk_d      = mk_q;
    fi_d      = fi_q;
    frem_d    = frem_q;
    res_d     = res_q;
    re        = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = 1'b0;
    div_start = 1'b0;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          res_d = '{status: cfba_pkg::ST_OK, alloc_start: '0};
          if (cmd_i.command == cfba_pkg::CMD_FREE) begin
            fi_d    = IW'(cmd_i.start_block);
            frem_d  = cmd_i.block_count;
            state_d = S_FREE;
          end else if (block_size_i == '0) begin
            res_d.status = cfba_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quot >= cfba_pkg::SIZE_W'(TOTAL_BLOCKS)) begin
            res_d.status = cfba_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            need_d  = CW'(div_quot) + 1'b1;
            ra_d    = '0;
            run_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Reads stream one address per cycle; checks use the registered read data.
        if (ra_q < CW'(TOTAL_BLOCKS)) begin
          re      = 1'b1;
          raddr   = ra_q[AW-1:0];
          pv_d    = 1'b1;
          paddr_d = ra_q[AW-1:0];
          ra_d    = ra_q + 1'b1;
        end
        if (pv_q) begin
          run_d = rdata_q ? '0 : run_inc;
          if (!rdata_q && run_inc == need_q) begin
            first_d = first_w[AW-1:0];
            mk_d    = first_w[AW-1:0];
            last_d  = paddr_q;
            pv_d    = 1'b0;
            state_d = S_MARK;
          end else if (paddr_q == LAST) begin
            res_d.status = cfba_pkg::ST_FULL;
            pv_d         = 1'b0;
            state_d      = S_DONE;
          end
        end
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = mk_q;
        wdata = 1'b1;
        mk_d  = mk_q + 1'b1;
        if (mk_q == last_q) begin
          res_d.alloc_start = first_ext[cfba_pkg::ALLOC_W-1:0];
          state_d           = S_DONE;
        end
      end
      S_FREE: begin
        if (frem_q != '0) begin
          re      = !fi_oob;
          raddr   = fi_q[AW-1:0];
          pv_d    = 1'b1;
          poob_d  = fi_oob;
          paddr_d = fi_q[AW-1:0];
          fi_d    = fi_q + 1'b1;
          frem_d  = frem_q - 1'b1;
        end
        if (pv_q) begin
          if (poob_q) begin
            res_d.status = cfba_pkg::ST_RANGE;
            pv_d         = 1'b0;
            state_d      = S_DONE;
          end else if (!rdata_q) begin
            res_d.status = cfba_pkg::ST_ALREADY;
            pv_d         = 1'b0;
            state_d      = S_DONE;
          end else begin
            we    = 1'b1;
            waddr = paddr_q;
          end
        end else if (frem_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pv_q    <= 1'b0;
      poob_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pv_q    <= pv_d;
      poob_q  <= poob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q    <= ra_d;
    paddr_q <= paddr_d;
    run_q   <= run_d;
    need_q  <= need_d;
    first_q <= first_d;
    last_q  <= last_d;
    mk_q    <= mk_d;
    fi_q    <= fi_d;
    frem_q  <= frem_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign idle_o      = state_q == S_IDLE;
  assign rsp_valid_o = state_q == S_DONE;
  assign rsp_o       = res_q;

  // The read and write ports never touch the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (re && we) |-> (raddr != waddr))
    else $error("bitmap read and write hit the same entry");

  // A run being marked never extends past the block where the scan found it.
  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (mk_q >= first_q && mk_q <= last_q))
    else $error("mark pointer left the found run");

  // The clearing pass runs once, right after reset.
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass re-entered");

  // The bitmap is never written while waiting for a command, the divider or a taker.
  a_quiet_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE || state_q == S_DIV) |-> !we)
    else $error("bitmap written outside an operation");

endmodule
